// ----- rtl/integer_to_radix_ascii_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit: assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITRA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Expression must never be true.
`define ITRA_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ----- rtl/itra_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit: package
// Widths, radix limits, character codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package itra_pkg;

  // Default width of the converted value.
  localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

  // Radix field.
  localparam int unsigned BASE_W = 6;
  localparam logic [BASE_W-1:0] MIN_BASE   = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE   = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_TEN  = 6'd10;
  localparam logic [BASE_W-1:0] LAST_DECIMAL_DIGIT = 6'd9;

  // Output characters.
  localparam int unsigned CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A_LOW = 8'h61;  // 'a'

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic busy;  // a division is in progress
    logic done;  // quotient and remainder are valid this cycle
  } itra_div_stat_t;

  // Digit value 0..35 to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-BASE_W){1'b0}}, d};
    if (d <= LAST_DECIMAL_DIGIT) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_A_LOW + ext - {{(CHAR_W-BASE_W){1'b0}}, RADIX_TEN};
    end
  endfunction

endpackage

// ----- rtl/itra_ram.sv -----
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/itra_div.sv -----
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit: radix divider
// Restoring divider, one quotient bit per cycle, for a 6-bit radix divisor.
// ----------------------------------------------------------------------------
`include "integer_to_radix_ascii_unit_defines.svh"

module itra_div #(
  parameter int unsigned VALUE_WIDTH = itra_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [VALUE_WIDTH-1:0]      dividend_i,
  input  logic [itra_pkg::BASE_W-1:0] radix_i,
  output itra_pkg::itra_div_stat_t    stat_o,
  output logic [VALUE_WIDTH-1:0]      quotient_o,
  output logic [itra_pkg::BASE_W-1:0] remainder_o
);

  import itra_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [BASE_W-1:0]      rem_q, rem_d;
  logic [BASE_W-1:0]      radix_q, radix_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  logic [BASE_W:0]        rem_shift;
  logic [BASE_W:0]        rem_sub;
  logic                   fits;

  // One restoring step: bring down the next dividend bit and try the radix.
  assign rem_shift = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, radix_q};
  assign fits      = (rem_shift >= {1'b0, radix_q});

  // Step control.
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d   = dividend_i;
      rem_d   = '0;
      radix_d = radix_i;
      cnt_d   = CNT_W'(VALUE_WIDTH - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? rem_sub[BASE_W-1:0] : rem_shift[BASE_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

  // The partial remainder always stays below the divisor.
  `ITRA_ASSERT_IMPLIES(a_rem_below_radix, busy_q || done_q, rem_q < radix_q, "remainder not below radix")
  // Completion is a single-cycle pulse.
  `ITRA_ASSERT_NEXT(a_done_pulse, done_q && !start_i, !done_q && !busy_q, "done held or busy after done")
  // A start loads the full step count.
  `ITRA_ASSERT_NEXT(a_start_loads, start_i, busy_q && (cnt_q == CNT_W'(VALUE_WIDTH - 1)), "start did not load divider")

endmodule

// ----- rtl/integer_to_radix_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// Integer to radix ASCII unit
// Converts an integer to ASCII text in radix 2..36, most significant digit
// first, one character per output transfer.
// ----------------------------------------------------------------------------
// Each digit comes from one pass of a bit-serial divider that retires one
// quotient bit per cycle. Digits are parked in a small RAM and read back in
// reverse; characters then leave while the output is not stalled, with a
// minus sign first where the number has one.
// The input is ready only while no conversion is in progress; the last
// character may still be waiting on the output when the next number is taken.
// The radix is clamped to 2..36, a minus sign appears only in radix ten.
`include "integer_to_radix_ascii_unit_defines.svh"

module integer_to_radix_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = itra_pkg::DEFAULT_VALUE_WIDTH,
  localparam int unsigned S_TDATA_W = ((VALUE_WIDTH + itra_pkg::BASE_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [S_TDATA_W-1:0]        s_axis_tdata,   // number, base, zero pad
  // Output stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [itra_pkg::CHAR_W-1:0] m_axis_tdata,   // character
  output logic                        m_axis_tlast    // last_char
);

  import itra_pkg::*;

  localparam int unsigned IDX_W = $clog2(VALUE_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              neg_q, neg_d;
  logic [BASE_W-1:0] radix_q, radix_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rd_ok_q, rd_ok_d;
  logic              m_valid_q, m_valid_d;
  logic [CHAR_W-1:0] m_char_q, m_char_d;
  logic              m_last_q, m_last_d;

  logic                   s_accept;
  logic [VALUE_WIDTH-1:0] in_number;
  logic [BASE_W-1:0]      in_base;
  logic [BASE_W-1:0]      base_sat;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] magnitude;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  itra_div_stat_t         div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [BASE_W-1:0]      div_rem;
  logic                   more_digits;

  logic              ram_we;
  logic [BASE_W-1:0] rd_digit;
  logic              out_free;

  // Input unpacking, radix clamp and sign handling.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_number     = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_base       = s_axis_tdata[VALUE_WIDTH +: BASE_W];

  always_comb begin
    if (in_base < MIN_BASE) begin
      base_sat = MIN_BASE;
    end else if (in_base > MAX_BASE) begin
      base_sat = MAX_BASE;
    end else begin
      base_sat = in_base;
    end
  end

  assign in_neg    = (base_sat == RADIX_TEN) && in_number[VALUE_WIDTH-1];
  assign magnitude = in_neg ? (~in_number + 1'b1) : in_number;

  // Divider: the first pass divides the magnitude, later passes the quotient.
  assign more_digits  = (div_quot != '0) && (idx_q != IDX_W'(VALUE_WIDTH - 1));
  assign div_start    = s_accept || ((state_q == ST_DIV) && div_stat.done && more_digits);
  assign div_dividend = s_accept ? magnitude : div_quot;

  itra_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .radix_i     (s_accept ? base_sat : radix_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Digit store, written least significant first, read back in reverse.
  assign ram_we = (state_q == ST_DIV) && div_stat.done;

  itra_ram #(
    .WIDTH (BASE_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (div_rem),
    .raddr_i (idx_q),
    .rdata_o (rd_digit)
  );

  // Sequencer and output register.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    radix_d   = radix_q;
    idx_d     = idx_q;
    rd_ok_d   = rd_ok_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          neg_d   = in_neg;
          radix_d = base_sat;
          idx_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          rd_ok_d = 1'b0;
          if (more_digits) begin
            idx_d = idx_q + 1'b1;
          end else if (neg_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = CHAR_MINUS;
          m_last_d  = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Read data is good once the RAM's registered read has caught up with the address, as rd_ok_q marks.
        if (rd_ok_q && out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = digit_char(rd_digit);
          m_last_d  = (idx_q == '0);
          rd_ok_d   = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_ok_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ok_q   <= rd_ok_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    radix_q  <= radix_d;
    idx_q    <= idx_d;
    m_char_q <= m_char_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_char_q;
  assign m_axis_tlast  = m_last_q;

  // A new number is never taken while the divider is still working.
  `ITRA_ASSERT_NEVER(a_ready_while_busy, s_axis_tready && div_stat.busy, "ready while dividing")
  // Digits read back are always below the radix.
  `ITRA_ASSERT_IMPLIES(a_digit_in_range, (state_q == ST_EMIT) && rd_ok_q, rd_digit < radix_q, "digit not below radix")
  // A minus sign is never the final character.
  `ITRA_ASSERT_IMPLIES(a_minus_not_last, m_axis_tvalid && (m_axis_tdata == CHAR_MINUS), !m_axis_tlast, "minus sign marked last")

endmodule
